[hdl/totp_pkg.sv]
// TOTP generator package: shared types, constants and SHA-1 helpers.
// Used by totp_ctrl, totp_dp and totp_code_generator.
package totp_pkg;

  localparam int unsigned CodeModulusDefault = 1000000;
  localparam int unsigned CodeW = 20;

  typedef enum logic [2:0] {
    CFG_KEY0 = 3'd0,
    CFG_KEY1 = 3'd1,
    CFG_KEY2 = 3'd2,
    CFG_KEY3 = 3'd3,
    CFG_KLEN = 3'd4,
    CFG_STEP = 3'd5
  } cfg_idx_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DIV,
    ST_LOAD,
    ST_ROUND,
    ST_FOLD,
    ST_TRUNC,
    ST_MOD,
    ST_OUT
  } ctrl_state_e;

  // Message sources for one compression, in processing order.
  typedef enum logic [1:0] {
    BLK_KEY_IPAD,
    BLK_INNER_TAIL,
    BLK_KEY_OPAD,
    BLK_OUTER_TAIL
  } blk_sel_e;

  typedef struct packed {
    logic     div_start;
    logic     load;
    blk_sel_e blk;
    logic     chain_init;
    logic     round;
    logic     fold;
    logic     save_ihash;
    logic     trunc;
  } dp_cmd_t;

  typedef struct packed {
    logic div_done;
    logic round_last;
    logic mod_done;
  } dp_sts_t;

  localparam logic [159:0] ShaInit =
    160'h67452301_EFCDAB89_98BADCFE_10325476_C3D2E1F0;

  function automatic logic [31:0] sha_k(input logic [6:0] r);
    logic [31:0] k;
    if (r < 7'd20) k = 32'h5A827999;
    else if (r < 7'd40) k = 32'h6ED9EBA1;
    else if (r < 7'd60) k = 32'h8F1BBCDC;
    else k = 32'hCA62C1D6;
    return k;
  endfunction

  function automatic logic [31:0] sha_f(input logic [6:0] r, input logic [31:0] b,
                                        input logic [31:0] c, input logic [31:0] d);
    logic [31:0] f;
    if (r < 7'd20) f = (b & c) | (~b & d);
    else if (r >= 7'd40 && r < 7'd60) f = (b & c) | (b & d) | (c & d);
    else f = b ^ c ^ d;
    return f;
  endfunction

endpackage

[hdl/totp_ctrl.sv]
// TOTP controller: sequences division, four SHA-1 compressions, truncation, modulo.
// Depends on totp_pkg.
module totp_ctrl
  import totp_pkg::*;
(
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    in_valid_i,
  output logic    in_ready_o,
  output logic    out_valid_o,
  input  logic    out_ready_i,
  input  dp_sts_t sts_i,
  output dp_cmd_t cmd_o
);

  ctrl_state_e state_q, state_d;
  logic [1:0]  blk_q, blk_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      blk_q   <= 2'd0;
    end else begin
      state_q <= state_d;
      blk_q   <= blk_d;
    end
  end

  always_comb begin
    state_d     = state_q;
    blk_d       = blk_q;
    cmd_o       = '0;
    cmd_o.blk   = blk_sel_e'(blk_q);
    in_ready_o  = 1'b0;
    out_valid_o = 1'b0;
    case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.div_start = 1'b1;
          state_d = ST_DIV;
        end
      end
      ST_DIV: begin
        if (sts_i.div_done) begin
          blk_d = 2'd0;
          state_d = ST_LOAD;
        end
      end
      ST_LOAD: begin
        cmd_o.load = 1'b1;
        // blocks 0 and 2 start a fresh chain
        cmd_o.chain_init = (blk_q == 2'd0) || (blk_q == 2'd2);
        state_d = ST_ROUND;
      end
      ST_ROUND: begin
        cmd_o.round = 1'b1;
        if (sts_i.round_last) state_d = ST_FOLD;
      end
      ST_FOLD: begin
        cmd_o.fold = 1'b1;
        cmd_o.save_ihash = (blk_q == 2'd1);
        if (blk_q == 2'd3) begin
          state_d = ST_TRUNC;
        end else begin
          blk_d = blk_q + 2'd1;
          state_d = ST_LOAD;
        end
      end
      ST_TRUNC: begin
        cmd_o.trunc = 1'b1;
        state_d = ST_MOD;
      end
      ST_MOD: begin
        if (sts_i.mod_done) state_d = ST_OUT;
      end
      ST_OUT: begin
        out_valid_o = 1'b1;
        if (out_ready_i) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

endmodule

[hdl/totp_dp.sv]
// TOTP datapath: restoring divider, SHA-1 round engine, truncation, modulo unit.
// Depends on totp_pkg; driven by totp_ctrl.
module totp_dp
  import totp_pkg::*;
#(
  parameter int unsigned CODE_MODULUS = CodeModulusDefault
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic [63:0]       unix_time_i,
  input  logic [255:0]      key_i,
  input  logic [5:0]        key_len_i,
  input  logic [31:0]       step_i,
  input  dp_cmd_t           cmd_i,
  output dp_sts_t           sts_o,
  output logic [CodeW-1:0]  code_o
);

  localparam logic [31:0] Modulus = 32'(CODE_MODULUS);
  localparam int unsigned RecipShift = 31 + $clog2(CODE_MODULUS);
  localparam logic [31:0] Recip = 32'((64'd1 << RecipShift) / 64'(CODE_MODULUS));

  // ---- counter = time / step, one quotient bit a cycle
  logic [63:0] dq_q, dq_d;
  logic [32:0] drem_q, drem_d;
  logic [31:0] dstep_q;
  logic [6:0]  dcnt_q, dcnt_d;
  logic        dbusy_q, dbusy_d;
  logic [32:0] dtry;

  always_comb begin
    dq_d = dq_q; drem_d = drem_q; dcnt_d = dcnt_q; dbusy_d = dbusy_q;
    dtry = {drem_q[31:0], dq_q[63]};
    if (cmd_i.div_start) begin
      dq_d = unix_time_i; drem_d = '0; dcnt_d = '0; dbusy_d = 1'b1;
    end else if (dbusy_q) begin
      if (dtry >= {1'b0, dstep_q}) begin
        drem_d = dtry - {1'b0, dstep_q};
        dq_d   = {dq_q[62:0], 1'b1};
      end else begin
        drem_d = dtry;
        dq_d   = {dq_q[62:0], 1'b0};
      end
      dcnt_d = dcnt_q + 7'd1;
      if (dcnt_q == 7'd63) dbusy_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dbusy_q <= 1'b0;
      dcnt_q  <= '0;
    end else begin
      dbusy_q <= dbusy_d;
      dcnt_q  <= dcnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    dq_q   <= dq_d;
    drem_q <= drem_d;
    if (cmd_i.div_start) dstep_q <= (step_i == 32'd0) ? 32'd1 : step_i;
  end

  assign sts_o.div_done = dbusy_q && (dcnt_q == 7'd63);

  // ---- masked key
  logic [255:0] kmask;
  logic [5:0]   klen;
  assign klen = (key_len_i > 6'd32) ? 6'd32 : key_len_i;
  always_comb begin
    for (int i = 0; i < 32; i++) begin
      kmask[255-8*i -: 8] = (6'(i) < klen) ? key_i[255-8*i -: 8] : 8'h00;
    end
  end

  // ---- message block select
  logic [159:0] ihash_q, h_q;
  logic [511:0] blk;
  always_comb begin
    case (cmd_i.blk)
      BLK_KEY_IPAD:   blk = {kmask, 256'h0} ^ {64{8'h36}};
      BLK_KEY_OPAD:   blk = {kmask, 256'h0} ^ {64{8'h5C}};
      BLK_INNER_TAIL: blk = {dq_q, 8'h80, 376'h0, 64'd576};
      BLK_OUTER_TAIL: blk = {ihash_q, 8'h80, 280'h0, 64'd672};
      default:        blk = '0;
    endcase
  end

  // ---- SHA-1 rounds, one per cycle, 16-word schedule window
  logic [511:0] w_q;
  logic [31:0]  a_q, b_q, c_q, d_q, e_q;
  logic [6:0]   rnd_q;
  logic [31:0]  wt, wnew, tsum, wx;

  assign wt   = w_q[511 -: 32];
  assign wx   = w_q[95:64] ^ w_q[255:224] ^ w_q[447:416] ^ w_q[511:480];
  assign wnew = {wx[30:0], wx[31]};
  assign tsum = {a_q[26:0], a_q[31:27]} + sha_f(rnd_q, b_q, c_q, d_q) + e_q
                + sha_k(rnd_q) + wt;
  assign sts_o.round_last = (rnd_q == 7'd79);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) rnd_q <= '0;
    else if (cmd_i.load) rnd_q <= '0;
    else if (cmd_i.round) rnd_q <= rnd_q + 7'd1;
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      w_q <= blk;
      if (cmd_i.chain_init) begin
        h_q <= ShaInit;
        {a_q, b_q, c_q, d_q, e_q} <= ShaInit;
      end else begin
        {a_q, b_q, c_q, d_q, e_q} <= h_q;
      end
    end else if (cmd_i.round) begin
      w_q <= {w_q[479:0], wnew};
      a_q <= tsum;
      b_q <= a_q;
      c_q <= {b_q[1:0], b_q[31:2]};
      d_q <= c_q;
      e_q <= d_q;
    end else if (cmd_i.fold) begin
      h_q[159:128] <= h_q[159:128] + a_q;
      h_q[127:96]  <= h_q[127:96]  + b_q;
      h_q[95:64]   <= h_q[95:64]   + c_q;
      h_q[63:32]   <= h_q[63:32]   + d_q;
      h_q[31:0]    <= h_q[31:0]    + e_q;
    end
    if (cmd_i.save_ihash) begin
      ihash_q <= {h_q[159:128] + a_q, h_q[127:96] + b_q, h_q[95:64] + c_q,
                  h_q[63:32] + d_q, h_q[31:0] + e_q};
    end
  end

  // ---- dynamic truncation
  logic [3:0]  off;
  logic [31:0] tword;
  assign off   = h_q[3:0];
  assign tword = h_q[159 - 8*off -: 32];

  // ---- modulo: reciprocal multiply, multiply back, one correction step
  logic [30:0] mw_q;
  logic [30:0] mqt_q;
  logic [31:0] mrem_q;
  logic [1:0]  mstg_q;
  logic [62:0] mprod;
  logic [31:0] mback;

  assign mprod = 63'(mw_q) * 63'(Recip);
  assign mback = 32'(mqt_q) * Modulus;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) mstg_q <= '0;
    else if (cmd_i.trunc) mstg_q <= 2'd1;
    else if (mstg_q != 2'd0) mstg_q <= mstg_q + 2'd1;
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.trunc) mw_q <= tword[30:0];
    if (mstg_q == 2'd1) mqt_q <= 31'(mprod >> RecipShift);
    if (mstg_q == 2'd2) mrem_q <= 32'(mw_q) - mback;
    else if (mstg_q == 2'd3 && mrem_q >= Modulus) mrem_q <= mrem_q - Modulus;
  end

  assign sts_o.mod_done = (mstg_q == 2'd3);
  assign code_o = mrem_q[CodeW-1:0];

  mod_bounded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (mstg_q == 2'd3) |-> ({1'b0, mrem_q} < {Modulus, 1'b0}))
    else $error("remainder out of range");
  div_bounded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    dbusy_q |-> (drem_q < {1'b0, dstep_q})) else $error("divider remainder out of range");
  rnd_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.round |-> (rnd_q < 7'd80)) else $error("round index overrun");

endmodule

[hdl/totp_code_generator.sv]
// TOTP code generator top level: configuration registers, controller, datapath.
// Depends on totp_pkg, totp_ctrl and totp_dp.
//
// Usage: write key bytes (regs 0-3), key length (4) and time step (5) on the
// cfg port while idle. Send a 64-bit Unix time on the s_axis channel; the
// 20-bit code appears on m_axis with one item out for every item in.
// From the accepting edge, an item passes through the counter divider
// (one quotient bit a cycle), the four SHA-1 compressions on a
// single round engine (inner key block, inner counter block, then the two
// outer blocks), truncation and the modulo unit (reciprocal
// multiply, multiply back, correction). One item is in flight at a time, so
// a new time is accepted only after the previous code has been handed off.
// Reset clears the key to zero, key length to 20 and time step to 30, and
// leaves the block ready for input. When the receiver stalls, the code is
// held on m_axis_tdata and no new item is accepted until it is taken.
module totp_code_generator
  import totp_pkg::*;
#(
  parameter int unsigned CODE_MODULUS = CodeModulusDefault
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [63:0] s_axis_tdata,   // [63:0] unix_time
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [23:0] m_axis_tdata,   // [19:0] code, [23:20] zero
  input  logic        cfg_we_i,
  input  logic [2:0]  cfg_idx_i,
  input  logic [63:0] cfg_data_i
);

  logic [255:0] key_q;
  logic [5:0]   klen_q;
  logic [31:0]  step_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      key_q  <= '0;
      klen_q <= 6'd20;
      step_q <= 32'd30;
    end else if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_idx_i))
        CFG_KEY0: key_q[255:192] <= cfg_data_i;
        CFG_KEY1: key_q[191:128] <= cfg_data_i;
        CFG_KEY2: key_q[127:64]  <= cfg_data_i;
        CFG_KEY3: key_q[63:0]    <= cfg_data_i;
        CFG_KLEN: klen_q <= cfg_data_i[5:0];
        CFG_STEP: step_q <= cfg_data_i[31:0];
        default: ;
      endcase
    end
  end

  dp_cmd_t          cmd;
  dp_sts_t          sts;
  logic [CodeW-1:0] code;

  totp_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  totp_dp #(.CODE_MODULUS(CODE_MODULUS)) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .unix_time_i (s_axis_tdata),
    .key_i       (key_q),
    .key_len_i   (klen_q),
    .step_i      (step_q),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .code_o      (code)
  );

  assign m_axis_tdata = {4'h0, code};

  no_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> !s_axis_tready) else $error("input taken while result pending");
  out_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tready) |=> $stable(m_axis_tdata))
    else $error("code changed under stall");
  one_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid && s_axis_tready) |=> !m_axis_tvalid) else $error("result too early");

endmodule

[dv/tb_totp_code_generator.sv]
// Testbench for totp_code_generator: drives Unix times on the input stream,
// predicts each six-digit code with its own HMAC-SHA1 model and checks it.
// Depends on totp_pkg and the totp_code_generator RTL.
`timescale 1ns / 100ps

module tb_totp_code_generator;
  import totp_pkg::*;

  localparam int unsigned Modulus = CodeModulusDefault;
  localparam int unsigned LimitCycles = 2_000_000;

  logic        clk_i;
  logic        rst_ni;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [63:0] s_axis_tdata;
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [23:0] m_axis_tdata;
  logic        cfg_we_i;
  logic [2:0]  cfg_idx_i;
  logic [63:0] cfg_data_i;

  totp_code_generator dut (.*);

  // predictor copy of the registers
  logic [63:0] key_words [4];
  logic [5:0]  key_len;
  logic [31:0] step_secs;

  logic [19:0] code_queue [$];
  int          n_fail;
  int          n_codes;
  int          n_sent;
  int          send_idle_pct;
  int          recv_idle_pct;
  int          hold_off;
  int unsigned cycles;

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  function automatic logic [31:0] rol(logic [31:0] x, int n);
    return (x << n) | (x >> (32 - n));
  endfunction

  // SHA-1 compression of one 512-bit block into chain h
  function automatic logic [159:0] sha1_compress(logic [159:0] h, logic [511:0] blk);
    logic [31:0] w [80];
    logic [31:0] a, b, c, d, e, f, k, t;
    for (int i = 0; i < 16; i++) w[i] = blk[511 - 32*i -: 32];
    for (int i = 16; i < 80; i++) w[i] = rol(w[i-3] ^ w[i-8] ^ w[i-14] ^ w[i-16], 1);
    {a, b, c, d, e} = h;
    for (int i = 0; i < 80; i++) begin
      if (i < 20) begin
        f = (b & c) | (~b & d); k = 32'h5A827999;
      end else if (i < 40) begin
        f = b ^ c ^ d; k = 32'h6ED9EBA1;
      end else if (i < 60) begin
        f = (b & c) | (b & d) | (c & d); k = 32'h8F1BBCDC;
      end else begin
        f = b ^ c ^ d; k = 32'hCA62C1D6;
      end
      t = rol(a, 5) + f + e + k + w[i];
      e = d; d = c; c = rol(b, 30); b = a; a = t;
    end
    return {h[159:128] + a, h[127:96] + b, h[95:64] + c, h[63:32] + d, h[31:0] + e};
  endfunction

  function automatic logic [19:0] totp_code(logic [63:0] unix_time);
    logic [511:0] key_blk;
    logic [255:0] key_all;
    logic [63:0]  counter;
    logic [63:0]  divisor;
    logic [159:0] ihash, digest;
    logic [31:0]  word;
    int unsigned  len, off;
    key_all = {key_words[0], key_words[1], key_words[2], key_words[3]};
    len = (key_len > 32) ? 32 : key_len;
    key_blk = '0;
    for (int i = 0; i < 32; i++)
      if (i < len) key_blk[511 - 8*i -: 8] = key_all[255 - 8*i -: 8];
    divisor = (step_secs == 0) ? 64'd1 : {32'd0, step_secs};
    counter = unix_time / divisor;
    // inner: 72 bytes -> two blocks; outer: 84 bytes -> two blocks
    ihash = sha1_compress(ShaInit, key_blk ^ {64{8'h36}});
    ihash = sha1_compress(ihash, {counter, 8'h80, 376'd0, 64'd576});
    digest = sha1_compress(ShaInit, key_blk ^ {64{8'h5C}});
    digest = sha1_compress(digest, {ihash, 8'h80, 280'd0, 64'd672});
    off = digest[3:0];
    word = digest[159 - 8*off -: 32];
    word[31] = 1'b0;
    return 20'(word % Modulus);
  endfunction

  task automatic write_reg(cfg_idx_e idx, logic [63:0] val);
    @(negedge clk_i);
    cfg_we_i = 1'b1; cfg_idx_i = idx; cfg_data_i = val;
    @(negedge clk_i);
    cfg_we_i = 1'b0;
    case (idx)
      CFG_KEY0: key_words[0] = val;
      CFG_KEY1: key_words[1] = val;
      CFG_KEY2: key_words[2] = val;
      CFG_KEY3: key_words[3] = val;
      CFG_KLEN: key_len = val[5:0];
      CFG_STEP: step_secs = val[31:0];
      default: ;
    endcase
  endtask

  task automatic send_time(logic [63:0] t);
    while (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) @(negedge clk_i);
    s_axis_tvalid = 1'b1;
    s_axis_tdata  = t;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    code_queue = {code_queue, totp_code(t)};
    n_sent++;
    @(negedge clk_i);
    s_axis_tvalid = 1'b0;
  endtask

  task automatic drain();
    while (code_queue.size() != 0) @(negedge clk_i);
    repeat (20) @(negedge clk_i);
  endtask

  function automatic logic [63:0] rand64();
    return {$urandom(), $urandom()};
  endfunction

  task automatic test_reset_values();
    send_time(64'd59);
    send_time(64'd0);
    send_time('1);
    drain();
  endtask

  task automatic test_key_and_step_extremes();
    // standard ASCII test key, 20 bytes
    write_reg(CFG_KEY0, 64'h3132333435363738);
    write_reg(CFG_KEY1, 64'h3930313233343536);
    write_reg(CFG_KEY2, 64'h3738393000000000);
    write_reg(CFG_KEY3, 64'hFFFF_FFFF_FFFF_FFFF);
    write_reg(CFG_KLEN, 64'd20);
    send_time(64'd59); send_time(64'd1111111109); send_time(64'd20000000000);
    drain();
    write_reg(CFG_KLEN, 64'd32);
    send_time(64'd59); send_time('1);
    drain();
    // above thirty-two saturates
    write_reg(CFG_KLEN, 64'd63);
    send_time(64'd1234567890);
    drain();
    write_reg(CFG_KLEN, 64'd0);
    send_time(64'd1234567890);
    drain();
    write_reg(CFG_STEP, 64'd0);          // zero step behaves as one
    send_time(64'd12345); send_time('1);
    drain();
    write_reg(CFG_STEP, 64'hFFFF_FFFF);
    send_time(64'hFFFF_FFFE); send_time(64'hFFFF_FFFF); send_time('1);
    drain();
    write_reg(CFG_STEP, 64'd1);
    send_time(64'h8000_0000_0000_0000); send_time(64'h5555_5555_AAAA_AAAA);
    drain();
  endtask

  task automatic test_random_times(int n_items);
    for (int i = 0; i < n_items; i++) begin
      if (i % 50 == 0) begin
        drain();
        write_reg(CFG_KEY0, rand64());
        write_reg(CFG_KEY1, rand64());
        write_reg(CFG_KEY2, rand64());
        write_reg(CFG_KEY3, rand64());
        write_reg(CFG_KLEN, 64'($urandom_range(63)));
        case ($urandom_range(3))
          0: write_reg(CFG_STEP, 64'd30);
          1: write_reg(CFG_STEP, 64'($urandom_range(3)));
          default: write_reg(CFG_STEP, {32'hFFFF_FFFF, $urandom()});
        endcase
      end
      case ($urandom_range(3))
        0: send_time({32'd0, $urandom()});
        1: send_time(64'($urandom_range(5)));
        default: send_time(rand64());
      endcase
    end
    drain();
  endtask

  task automatic test_backpressure();
    hold_off = 2000;
    send_idle_pct = 0;
    for (int i = 0; i < 4; i++) send_time(rand64());
    drain();
  endtask

  // receiver ready, with a counted long hold-off when requested
  always @(negedge clk_i) begin
    if (hold_off > 0) begin
      hold_off <= hold_off - 1;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= !(recv_idle_pct > 0 && $urandom_range(99) < recv_idle_pct);
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (code_queue.size() == 0) begin
        $error("unexpected code %0d", m_axis_tdata[19:0]);
        n_fail++;
      end else begin
        if (m_axis_tdata[19:0] !== code_queue[0]) begin
          $error("code: expected %0d, actual %0d", code_queue[0], m_axis_tdata[19:0]);
          n_fail++;
        end
        void'(code_queue.pop_front());
        n_codes++;
      end
    end
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > LimitCycles) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  initial begin
    cycles = 0; n_fail = 0; n_codes = 0; n_sent = 0; hold_off = 0;
    send_idle_pct = 0; recv_idle_pct = 0;
    rst_ni = 1'b0;
    s_axis_tvalid = 1'b0; s_axis_tdata = '0;
    m_axis_tready = 1'b0;
    cfg_we_i = 1'b0; cfg_idx_i = CFG_KEY0; cfg_data_i = '0;
    key_words = '{default: '0}; key_len = 6'd20; step_secs = 32'd30;
    repeat (6) @(negedge clk_i);
    rst_ni = 1'b1;
    test_reset_values();
    test_key_and_step_extremes();
    send_idle_pct = 32; recv_idle_pct = 51;
    test_random_times(200);
    send_idle_pct = 51; recv_idle_pct = 32;
    test_random_times(200);
    send_idle_pct = 0; recv_idle_pct = 0;
    test_random_times(200);
    test_backpressure();
    $display("Sent %0d times, checked %0d codes across key lengths 0..63 and steps 0..max",
             n_sent, n_codes);
    if (n_fail == 0 && code_queue.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

[totp_code_generator.f]
hdl/totp_pkg.sv
hdl/totp_ctrl.sv
hdl/totp_dp.sv
hdl/totp_code_generator.sv
dv/tb_totp_code_generator.sv
